// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
// depends on nothing; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sgsa_pkg.sv =====
// shared constants and types for the stereo gaze servo angle unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sgsa_pkg;
	localparam int CoordW = 19;
	localparam int DiffW  = 21;
	localparam int CordW  = 40;   // x,y datapath: diff * 2^16 plus growth
	localparam int AccW   = 28;   // angle accumulator, 2^-24 rad
	localparam int AngW   = 18;   // angle in 2^-14 rad
	localparam int PosW   = 11;
	localparam int TabLen = 24;
	localparam logic signed [AccW-1:0] PiQ24 = 28'sd52707179;

	typedef enum logic [2:0] {
		REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_HALF_SPACING,
		REG_PAN_MIN, REG_PAN_MAX, REG_TILT_MIN, REG_TILT_MAX
	} reg_idx_t;

	function automatic logic signed [AccW-1:0] atan_tab(input int i);
		logic signed [AccW-1:0] r;
		case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			default: r = (i < TabLen) ? (28'sd65536 >>> (i - 8)) : 28'sd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/sgsa_cordic.sv =====
// pipelined atan2 by cordic vectoring, one rotation per stage
// depends on sgsa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sgsa_cordic import sgsa_pkg::*; #(
	parameter int Steps = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [DiffW-1:0] x_in,
	input  wire logic signed [DiffW-1:0] y_in,
	output logic                         out_valid,
	output logic signed [AngW-1:0]       angle
);
	localparam int N = (Steps < TabLen) ? Steps : TabLen;

	logic                   v_s [N+1];
	logic                   z_s [N+1];
	logic signed [CordW-1:0] x_s [N+1];
	logic signed [CordW-1:0] y_s [N+1];
	logic signed [AccW-1:0]  a_s [N+1];

	// quadrant fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		z_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			x_s[0] <= -({{(CordW-DiffW-16){x_in[DiffW-1]}}, x_in, 16'd0});
			y_s[0] <= -({{(CordW-DiffW-16){y_in[DiffW-1]}}, y_in, 16'd0});
			a_s[0] <= (y_in >= 0) ? PiQ24 : -PiQ24;
		end else begin
			x_s[0] <= {{(CordW-DiffW-16){x_in[DiffW-1]}}, x_in, 16'd0};
			y_s[0] <= {{(CordW-DiffW-16){y_in[DiffW-1]}}, y_in, 16'd0};
			a_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			if (!y_s[i][CordW-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] + atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] - atan_tab(i);
			end
		end
	end

	logic signed [AccW-1:0] rnd;
	assign rnd = a_s[N] + 28'sd512;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end
	always_ff @(posedge clk) begin
		angle <= z_s[N] ? '0 : rnd[AccW-1:10];
	end

	`ASSERT_NEXT(a_valid_flow, clk, arst_n, v_s[N], out_valid, "cordic valid lost")
	`ASSERT_NEXT(a_no_ghost, clk, arst_n, !v_s[N], !out_valid, "cordic valid invented")
	`ASSERT_NEXT(a_zero_angle, clk, arst_n, v_s[N] && z_s[N], angle == '0, "zero vector angle")
endmodule
`default_nettype wire

// ===== sv/sgsa_scale.sv =====
// clamp an angle to limits, scale by reciprocal and map to 0..2000
// depends on sgsa_pkg; three register stages
`timescale 1ns / 1ps
`default_nettype none
module sgsa_scale import sgsa_pkg::*; #(
	parameter int Range = 11436
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [AngW-1:0]  angle,
	input  wire logic signed [15:0]      lo,
	input  wire logic signed [15:0]      hi,
	output logic                         out_valid,
	output logic [PosW-1:0]              position
);
	localparam longint Recip = (64'd1000 * 64'd16777216 + Range / 2) / Range;
	localparam logic signed [47:0] Lim = 48'sd16777216000;

	logic signed [AngW-1:0] c0, c1;
	logic signed [AngW-1:0] ang_s1;
	logic                   v_s1;
	logic signed [47:0]     q_s2;
	logic                   v_s2;
	logic signed [47:0]     qs;
	logic signed [47:0]     sum;

	always_comb begin
		c0 = (angle < AngW'(lo)) ? AngW'(lo) : angle;
		c1 = (c0 > AngW'(hi)) ? AngW'(hi) : c0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= c1;
		q_s2 <= 48'(ang_s1) * $signed({1'b0, 31'(Recip)});
	end

	always_comb begin
		qs = (q_s2 > Lim) ? Lim : ((q_s2 < -Lim) ? -Lim : q_s2);
		sum = qs + Lim;
	end

	always_ff @(posedge clk) begin
		position <= sum[24 +: PosW];
	end
endmodule
`default_nettype wire

// ===== sv/stereo_gaze_servo_angles_unit.sv =====
// top level: origin offset, three cordic pipelines and output scaling
// depends on sgsa_pkg, sgsa_cordic, sgsa_scale
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One target point enters per clock when start is pulsed; busy is always low.
// On its way to the done strobe each point passes one offset stage, a fold
// stage, one stage per cordic rotation (CordicSteps, capped at TabLen), a
// rounding stage and three scaling stages. The receiver cannot stall, and
// none is needed since every stage advances every cycle.
module stereo_gaze_servo_angles_unit import sgsa_pkg::*; #(
	parameter int PanRange    = 11436,
	parameter int TiltRange   = 11436,
	parameter int CordicSteps = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [CoordW-1:0] target_x,
	input  wire logic signed [CoordW-1:0] target_y,
	input  wire logic signed [CoordW-1:0] target_z,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [18:0]              cfg_data,
	output logic                          done,
	output logic [PosW-1:0]               tilt_position,
	output logic [PosW-1:0]               left_pan_position,
	output logic [PosW-1:0]               right_pan_position
);
	logic signed [18:0] org_x_q, org_y_q, org_z_q;
	logic [15:0]        hs_q;
	logic signed [15:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= 19'sd3932;
			org_y_q <= '0;
			org_z_q <= 19'sd5898;
			hs_q <= 16'd2621;
			pan_min_q <= -16'sd11436;
			pan_max_q <= 16'sd11436;
			tilt_min_q <= -16'sd11436;
			tilt_max_q <= 16'sd11436;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:     org_x_q <= cfg_data;
				REG_ORIGIN_Y:     org_y_q <= cfg_data;
				REG_ORIGIN_Z:     org_z_q <= cfg_data;
				REG_HALF_SPACING: hs_q <= cfg_data[15:0];
				REG_PAN_MIN:      pan_min_q <= cfg_data[15:0];
				REG_PAN_MAX:      pan_max_q <= cfg_data[15:0];
				REG_TILT_MIN:     tilt_min_q <= cfg_data[15:0];
				REG_TILT_MAX:     tilt_max_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic                    v_s1;
	logic signed [DiffW-1:0] dx_s1, dz_s1, dl_s1, dr_s1;
	logic signed [DiffW-1:0] dy;
	assign dy = DiffW'(target_y) - DiffW'(org_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		dx_s1 <= DiffW'(target_x) - DiffW'(org_x_q);
		dz_s1 <= DiffW'(target_z) - DiffW'(org_z_q);
		dl_s1 <= dy - DiffW'($signed({1'b0, hs_q}));
		dr_s1 <= dy + DiffW'($signed({1'b0, hs_q}));
	end

	logic                  cv_t, cv_l, cv_r;
	logic signed [AngW-1:0] a_t, a_l, a_r;
	logic                  sv_t, sv_l, sv_r;

	sgsa_cordic #(.Steps(CordicSteps)) u_cor_t (.clk, .arst_n, .in_valid(v_s1),
		.x_in(dx_s1), .y_in(dz_s1), .out_valid(cv_t), .angle(a_t));
	sgsa_cordic #(.Steps(CordicSteps)) u_cor_l (.clk, .arst_n, .in_valid(v_s1),
		.x_in(dx_s1), .y_in(dl_s1), .out_valid(cv_l), .angle(a_l));
	sgsa_cordic #(.Steps(CordicSteps)) u_cor_r (.clk, .arst_n, .in_valid(v_s1),
		.x_in(dx_s1), .y_in(dr_s1), .out_valid(cv_r), .angle(a_r));

	sgsa_scale #(.Range(TiltRange)) u_sc_t (.clk, .arst_n, .in_valid(cv_t), .angle(a_t),
		.lo(tilt_min_q), .hi(tilt_max_q), .out_valid(sv_t), .position(tilt_position));
	sgsa_scale #(.Range(PanRange)) u_sc_l (.clk, .arst_n, .in_valid(cv_l), .angle(a_l),
		.lo(pan_min_q), .hi(pan_max_q), .out_valid(sv_l), .position(left_pan_position));
	sgsa_scale #(.Range(PanRange)) u_sc_r (.clk, .arst_n, .in_valid(cv_r), .angle(a_r),
		.lo(pan_min_q), .hi(pan_max_q), .out_valid(sv_r), .position(right_pan_position));

	assign done = sv_t;

	`ASSERT_IMPL(a_lanes_aligned, clk, arst_n, 1'b1, (sv_t == sv_l) && (sv_l == sv_r),
		"lanes out of step")
	`ASSERT_IMPL(a_pos_range, clk, arst_n, done, tilt_position <= 11'd2000,
		"tilt beyond 2000")
	`ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
endmodule
`default_nettype wire
